### rtl/short_label_run_merge_macros.svh
// ----------------------------------------------------------------------------
// short_label_run_merge_macros.svh
// Assertion shorthands used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef SHORT_LABEL_RUN_MERGE_MACROS_SVH
`define SHORT_LABEL_RUN_MERGE_MACROS_SVH

// clocked property, switched off while reset is low
`define SRM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that is checked on every edge
`define SRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants of the label run-merge filter.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int MAX_RUN_DEF = 32;  // default run length ceiling
  localparam int LABEL_W     = 3;
  localparam int CFG_W       = 6;   // min_run_length register width
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_RUN = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT1,   // drain the run that just closed
    ST_EMIT2    // drain labels released by the current item
  } state_t;

  typedef struct packed {
    logic load;   // take the input item, update chain state
    logic dec1;   // one label of the closed run delivered
    logic dec2;   // one label of the second group delivered
    logic sel2;   // output shows the second group
  } dp_cmd_t;

  typedef struct packed {
    logic n1_nz;  // item closes a run with held labels
    logic n2_nz;  // item releases labels of its own run
    logic last1;  // one label of the first group left
    logic last2;  // one label of the second group left
  } dp_sts_t;

endpackage

### rtl/short_label_run_merge.sv
// ----------------------------------------------------------------------------
// short_label_run_merge
// Run-length smoothing of a chain of class labels.
// ----------------------------------------------------------------------------
// Labels of a run are held until the run ends or reaches the minimum length,
// then delivered in a burst, so results may trail the input by up to a run.
// The block takes one item at a time: it accepts an item, then each result
// it causes goes out through the output register at one per cycle while
// the result side does not stall (an item causes from 0 up to MAX_RUN
// results). The input is not ready while results of the previous item are
// pending.
module short_label_run_merge #(
  parameter int MAX_RUN = srm_pkg::MAX_RUN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [srm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [2:0] label
  input  logic                            in_tlast,   // chain_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [2:0] label_out
  output logic                            out_tlast,  // chain_end_out
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [srm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [srm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [srm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  logic [srm_pkg::CFG_W-1:0]   min_run_length;
  logic [srm_pkg::LABEL_W-1:0] label_out;
  srm_pkg::dp_cmd_t            cmd;
  srm_pkg::dp_sts_t            sts;

  srm_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .min_run_length (min_run_length)
  );

  srm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  srm_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_run_length (min_run_length),
    .in_label       (in_tdata[srm_pkg::LABEL_W-1:0]),
    .in_end         (in_tlast),
    .cmd            (cmd),
    .sts            (sts),
    .out_label      (label_out),
    .out_last       (out_tlast)
  );

  assign out_tdata = srm_pkg::OUT_TDATA_W'(label_out);

endmodule

### rtl/srm_cfg.sv
// ----------------------------------------------------------------------------
// srm_cfg
// APB register slice holding the minimum run length.
// ----------------------------------------------------------------------------
module srm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [srm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [srm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [srm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output logic [srm_pkg::CFG_W-1:0]        min_run_length
);

  logic [srm_pkg::CFG_W-1:0] min_run_r;
  logic [srm_pkg::CFG_W-1:0] min_run_nxt;
  logic                      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == srm_pkg::REG_MIN_RUN);

  always_comb begin
    min_run_nxt = min_run_r;
    if (wr_en) begin
      min_run_nxt = cfg_pwdata[srm_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r <= '0;
    end else begin
      min_run_r <= min_run_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == srm_pkg::REG_MIN_RUN) begin
      cfg_prdata = srm_pkg::CFG_DATA_W'(min_run_r);
    end
  end

  assign min_run_length = min_run_r;

endmodule

### rtl/srm_ctrl.sv
// ----------------------------------------------------------------------------
// srm_ctrl
// Sequencer: takes one item, then drains its result labels one per cycle unless stalled.
// ----------------------------------------------------------------------------
module srm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output srm_pkg::dp_cmd_t cmd,
  input  srm_pkg::dp_sts_t sts
);

  srm_pkg::state_t state_r;
  srm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    case (state_r)
      srm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.n1_nz) begin
            state_nxt = srm_pkg::ST_EMIT1;
          end else if (sts.n2_nz) begin
            state_nxt = srm_pkg::ST_EMIT2;
          end
        end
      end
      srm_pkg::ST_EMIT1: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.dec1 = 1'b1;
          if (sts.last1) begin
            state_nxt = sts.n2_nz ? srm_pkg::ST_EMIT2 : srm_pkg::ST_IDLE;
          end
        end
      end
      srm_pkg::ST_EMIT2: begin
        out_tvalid = 1'b1;
        cmd.sel2   = 1'b1;
        if (out_tready) begin
          cmd.dec2 = 1'b1;
          if (sts.last2) begin
            state_nxt = srm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = srm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/srm_dp.sv
// ----------------------------------------------------------------------------
// srm_dp
// Run tracking, merge decision and result group counters.
// ----------------------------------------------------------------------------
module srm_dp #(
  parameter int MAX_RUN = srm_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [srm_pkg::CFG_W-1:0]     min_run_length,
  input  logic [srm_pkg::LABEL_W-1:0]   in_label,
  input  logic                          in_end,
  input  srm_pkg::dp_cmd_t              cmd,
  output srm_pkg::dp_sts_t              sts,
  output logic [srm_pkg::LABEL_W-1:0]   out_label,
  output logic                          out_last
);

  localparam int CW   = $clog2(MAX_RUN + 1);
  localparam int CfgW = srm_pkg::CFG_W;
  localparam logic [CfgW-1:0] MaxRunCfg = CfgW'(MAX_RUN);
  localparam logic [CW-1:0]   MaxRunCnt = CW'(MAX_RUN);
  localparam logic [CW-1:0]   One       = CW'(1);

  logic [srm_pkg::LABEL_W-1:0] left_r, left_nxt;
  logic [srm_pkg::LABEL_W-1:0] runc_r, runc_nxt;
  logic [CW-1:0]               held_r, held_nxt;
  logic                        first_r, first_nxt;
  logic                        rel_r, rel_nxt;
  logic [CW-1:0]               cnt1_r, cnt1_nxt;
  logic [srm_pkg::LABEL_W-1:0] cls1_r, cls1_nxt;
  logic [CW-1:0]               cnt2_r, cnt2_nxt;
  logic [srm_pkg::LABEL_W-1:0] cls2_r, cls2_nxt;
  logic                        end2_r, end2_nxt;

  logic [CW-1:0]               min_eff;
  logic                        run_open;
  logic                        run_ends;
  logic                        merge;
  logic [srm_pkg::LABEL_W-1:0] close_cls;
  logic [CW-1:0]               n1;
  logic [CW-1:0]               n2;
  logic [CW-1:0]               held_a;
  logic [CW-1:0]               held_b;
  logic                        rel_a;
  logic [srm_pkg::LABEL_W-1:0] runc_a;

  always_comb begin
    if (min_run_length > MaxRunCfg) begin
      min_eff = MaxRunCnt;
    end else begin
      min_eff = CW'(min_run_length);
    end
    if (min_eff == '0) begin
      min_eff = One;
    end
  end

  // decision for the item on the input port
  always_comb begin
    run_open  = (held_r != '0) || rel_r;
    run_ends  = run_open && (in_label != runc_r);
    merge     = !first_r && !rel_r && (held_r != '0) && (held_r < min_eff) &&
                (in_label == left_r);
    close_cls = merge ? left_r : runc_r;
    n1        = run_ends ? held_r : '0;
    held_a    = run_ends ? '0 : held_r;
    rel_a     = run_ends ? 1'b0 : rel_r;
    runc_a    = (run_ends || !run_open) ? in_label : runc_r;
    held_b    = held_a + One;

    left_nxt  = run_ends ? close_cls : left_r;
    first_nxt = run_ends ? 1'b0 : first_r;
    runc_nxt  = runc_a;
    held_nxt  = held_a;
    rel_nxt   = rel_a;
    n2        = '0;
    if (rel_a) begin
      n2 = One;
    end else if (in_end) begin
      n2 = held_b;
    end else if (held_b >= min_eff) begin
      n2       = held_b;
      held_nxt = '0;
      rel_nxt  = 1'b1;
    end else begin
      held_nxt = held_b;
    end
    if (in_end) begin
      left_nxt  = '0;
      runc_nxt  = '0;
      held_nxt  = '0;
      first_nxt = 1'b1;
      rel_nxt   = 1'b0;
    end
  end

  always_comb begin
    cnt1_nxt = cnt1_r;
    cls1_nxt = cls1_r;
    cnt2_nxt = cnt2_r;
    cls2_nxt = cls2_r;
    end2_nxt = end2_r;
    if (cmd.load) begin
      cnt1_nxt = n1;
      cls1_nxt = close_cls;
      cnt2_nxt = n2;
      cls2_nxt = runc_a;
      end2_nxt = in_end;
    end
    if (cmd.dec1) begin
      cnt1_nxt = cnt1_r - One;
    end
    if (cmd.dec2) begin
      cnt2_nxt = cnt2_r - One;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      runc_r  <= '0;
      held_r  <= '0;
      first_r <= 1'b1;
      rel_r   <= 1'b0;
      cnt1_r  <= '0;
      cnt2_r  <= '0;
    end else begin
      if (cmd.load) begin
        left_r  <= left_nxt;
        runc_r  <= runc_nxt;
        held_r  <= held_nxt;
        first_r <= first_nxt;
        rel_r   <= rel_nxt;
      end
      cnt1_r <= cnt1_nxt;
      cnt2_r <= cnt2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls1_r <= cls1_nxt;
    cls2_r <= cls2_nxt;
    end2_r <= end2_nxt;
  end

  always_comb begin
    sts.n1_nz = (n1 != '0);
    sts.n2_nz = cmd.load ? (n2 != '0) : (cnt2_r != '0);
    sts.last1 = (cnt1_r == One);
    sts.last2 = (cnt2_r == One);
  end

  assign out_label = cmd.sel2 ? cls2_r : cls1_r;
  assign out_last  = cmd.sel2 && end2_r && (cnt2_r == One);

endmodule

### rtl/srm_chk.sv
// ----------------------------------------------------------------------------
// srm_chk
// Port-level checks of the label run-merge filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "short_label_run_merge_macros.svh"

module srm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [srm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // results drain before the next item is taken
  `SRM_ASSERT(a_no_overlap, clk, rst_n, !(out_tvalid && in_tready), "input ready while results pending")

  // a chain end always yields at least one result
  `SRM_ASSERT(a_end_emits, clk, rst_n, (in_tvalid && in_tready && in_tlast) |=> out_tvalid, "chain end produced no result")

  // the final label of a chain frees the input
  `SRM_ASSERT(a_free_after_last, clk, rst_n, (out_tvalid && out_tready && out_tlast) |=> in_tready, "input not ready after chain end")

  `SRM_ASSERT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled result changed")

endmodule

bind short_label_run_merge srm_chk u_srm_chk (.*);

### tb/tb_short_label_run_merge.sv
// ----------------------------------------------------------------------------
// tb_short_label_run_merge
// Self-checking bench for the label run-merge filter.
// ----------------------------------------------------------------------------
// Label chains go in on the input stream. A cycle-free model of the run
// smoothing predicts every output label, and each request on the output
// stream is checked against it in order. The minimum run length register is
// written over APB while the block is idle, and read back. Directed chains
// hit the merge rules, a change of the register inside a chain, saturation
// and the longest bursts. Random chains are built from runs around the
// minimum length. Both stream sides idle at random, and one stretch holds
// the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_short_label_run_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LABEL_W     = srm_pkg::LABEL_W;
  localparam int CFG_W       = srm_pkg::CFG_W;
  localparam int IN_TDATA_W  = srm_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = srm_pkg::OUT_TDATA_W;
  localparam int CFG_ADDR_W  = srm_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = srm_pkg::CFG_DATA_W;

  localparam int RUN_CEIL     = srm_pkg::MAX_RUN_DEF;
  localparam int RANDOM_ITEMS = 35;
  localparam int QUIET_LIMIT  = 5000;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               is_end;
  } label_rec_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // [2:0] label
  logic                   in_tlast    = 1'b0; // chain_end
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [2:0] label_out
  logic                   out_tlast;          // chain_end_out
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  short_label_run_merge i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // smoothing model state
  logic [CFG_W-1:0]   min_run_cfg  = '0;
  logic [LABEL_W-1:0] left_cls     = '0;
  logic [LABEL_W-1:0] run_cls      = '0;
  int                 held_cnt     = 0;
  bit                 first_run    = 1'b1;
  bit                 run_released = 1'b0;

  label_rec_t pending_labels[$];
  label_rec_t head_rec;

  int tx_gap_max       = 0;
  int rx_gap_max       = 0;
  int sink_hold_cycles = 0;
  int mismatches       = 0;
  int labels_sent      = 0;
  int chains_sent      = 0;
  int results_checked  = 0;
  int cfg_writes       = 0;
  int quiet_cycles     = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < 30) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void queue_labels(input int n, input logic [LABEL_W-1:0] cls,
                                       input bit end_last);
    label_rec_t rec;
    for (int i = 0; i < n; i++) begin
      rec.label  = cls;
      rec.is_end = end_last && (i == n - 1);
      pending_labels = {pending_labels, rec};
    end
  endfunction

  function automatic void predict_labels(input logic [LABEL_W-1:0] lab, input bit is_end);
    int               eff;
    bit               run_open;
    bit               merge;
    logic [LABEL_W-1:0] cls;
    eff = (min_run_cfg > RUN_CEIL) ? RUN_CEIL : int'(min_run_cfg);
    if (eff < 1) eff = 1;
    run_open = (held_cnt > 0) || run_released;
    if (run_open && lab != run_cls) begin
      // run closes: short inner run sandwiched by its left class gets merged
      merge = !first_run && !run_released && held_cnt > 0 && held_cnt < eff &&
              lab == left_cls;
      cls = merge ? left_cls : run_cls;
      queue_labels(held_cnt, cls, 1'b0);
      left_cls     = cls;
      first_run    = 1'b0;
      held_cnt     = 0;
      run_released = 1'b0;
      run_cls      = lab;
    end else if (!run_open) begin
      run_cls = lab;
    end
    if (run_released) begin
      queue_labels(1, run_cls, is_end);
    end else begin
      held_cnt++;
      if (is_end) begin
        queue_labels(held_cnt, run_cls, 1'b1);
      end else if (held_cnt >= eff) begin
        queue_labels(held_cnt, run_cls, 1'b0);
        held_cnt     = 0;
        run_released = 1'b1;
      end
    end
    if (is_end) begin
      left_cls     = '0;
      run_cls      = '0;
      held_cnt     = 0;
      first_run    = 1'b1;
      run_released = 1'b0;
    end
  endfunction

  // valid stays high between back-to-back requests; lowered only before a gap
  task automatic send_label(input logic [LABEL_W-1:0] lab, input bit is_end);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-LABEL_W){1'b0}}, lab};
    in_tlast  <= is_end;
    do @(posedge clk); while (!in_tready);
    predict_labels(lab, is_end);
    labels_sent++;
    if (is_end) chains_sent++;
  endtask

  task automatic drain_results(input int settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_labels.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // write then read back, only with the block idle
  task automatic write_min_run(input logic [CFG_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    drain_results(4);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= srm_pkg::REG_MIN_RUN;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    min_run_cfg = value;
    cfg_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd !== CFG_DATA_W'(value))
      report_mismatch($sformatf("min_run_length reads %0d, wrote %0d", rd, value));
  endtask

  task automatic send_chain(input logic [LABEL_W-1:0] labs[], input bit close_chain);
    foreach (labs[i]) send_label(labs[i], close_chain && (i == labs.size() - 1));
  endtask

  // runs around the minimum length; from the third run on, a run often repeats
  // the class two runs back so the merge can fire
  task automatic send_random_chain(input int eff);
    int                 n_runs;
    int                 run_len;
    int                 len_cap;
    int                 n;
    bit                 cut;
    logic [LABEL_W-1:0] lab;
    logic [LABEL_W-1:0] prev_lab;
    logic [LABEL_W-1:0] prev2_lab;
    cut       = ($urandom_range(0, 7) == 0);
    prev_lab  = '0;
    prev2_lab = '0;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        send_label(LABEL_W'($urandom_range(0, 7)), !cut && (i == n - 1));
    end else begin
      n_runs  = $urandom_range(1, 6);
      len_cap = (eff < 4) ? eff + 1 : 4;
      for (int r = 0; r < n_runs; r++) begin
        if (r >= 2 && $urandom_range(0, 2) != 0) begin
          lab = prev2_lab;
        end else begin
          do lab = LABEL_W'($urandom_range(0, 7)); while (r > 0 && lab == prev_lab);
        end
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, eff + 1)
                                              : $urandom_range(1, len_cap);
        for (int i = 0; i < run_len; i++)
          send_label(lab, !cut && (r == n_runs - 1) && (i == run_len - 1));
        prev2_lab = prev_lab;
        prev_lab  = lab;
      end
    end
  endtask

  task automatic test_pass_through();
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_chain('{3'd0, 3'd7, 3'd7, 3'd3}, 1'b1);
    send_chain('{3'd4}, 1'b1);
    drain_results(4);
  endtask

  task automatic test_merge_rules();
    write_min_run(6'd3);
    tx_gap_max = 19;
    rx_gap_max = 19;
    // short first run kept, short inner run merged into its neighbors
    send_chain('{3'd5, 3'd6, 3'd6, 3'd6, 3'd2, 3'd6, 3'd6, 3'd6}, 1'b1);
    // a merge keeps the left class, the next short run merges against it
    send_chain('{3'd2, 3'd2, 3'd5, 3'd2, 3'd6, 3'd2}, 1'b1);
    // short last run stays as is
    send_chain('{3'd1, 3'd4}, 1'b1);
    drain_results(4);
  endtask

  task automatic test_config_mid_chain();
    write_min_run(6'd8);
    tx_gap_max = 0;
    rx_gap_max = 0;
    send_chain('{3'd2, 3'd2, 3'd2, 3'd2}, 1'b0);
    write_min_run(6'd3);
    send_chain('{3'd2, 3'd7}, 1'b1);
    drain_results(4);
  endtask

  task automatic test_saturation();
    logic [LABEL_W-1:0] labs[];
    tx_gap_max = 0;
    rx_gap_max = 0;
    // ceiling reached: a full run goes out in one burst
    write_min_run(6'd63);
    labs = new[33];
    foreach (labs[i]) labs[i] = (i < 32) ? 3'd7 : 3'd0;
    send_chain(labs, 1'b1);
    // held run of ceiling-1 flushed together with the chain's last label
    write_min_run(6'd40);
    labs = new[32];
    foreach (labs[i]) labs[i] = (i < 31) ? 3'd3 : 3'd2;
    send_chain(labs, 1'b1);
    drain_results(4);
  endtask

  task automatic test_backpressure();
    write_min_run(6'd0);
    tx_gap_max       = 0;
    rx_gap_max       = 0;
    sink_hold_cycles = 300;
    for (int i = 0; i < 24; i++) send_label(LABEL_W'($urandom_range(0, 7)), i == 23);
    drain_results(4);
  endtask

  task automatic test_random_chains();
    logic [CFG_W-1:0] preset_mins[8] = '{6'd2, 6'd3, 6'd32, 6'd0, 6'd1, 6'd63, 6'd5, 6'd33};
    logic [CFG_W-1:0] setting;
    int               phase;
    int               eff;
    int               start_count;
    int               phase_end;
    phase       = 0;
    start_count = labels_sent;
    while (labels_sent - start_count < RANDOM_ITEMS) begin
      setting = (phase < 8) ? preset_mins[phase] : CFG_W'($urandom_range(0, 63));
      write_min_run(setting);
      eff = (setting > RUN_CEIL) ? RUN_CEIL : int'(setting);
      if (eff < 1) eff = 1;
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      phase_end  = labels_sent + 15 + $urandom_range(0, 10);
      while (labels_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) drain_results(0);
        send_random_chain(eff);
      end
      phase++;
    end
    // close whatever chain a cut left open
    send_label(LABEL_W'($urandom_range(0, 7)), 1'b1);
    drain_results(4);
  endtask

  // result side: random stall per request, plus an optional long hold
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (sink_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_labels.size() == 0) begin
        report_mismatch($sformatf("unexpected label %0d last %0b", out_tdata, out_tlast));
      end else begin
        head_rec = pending_labels.pop_front();
        results_checked++;
        if (out_tdata !== {{(OUT_TDATA_W-LABEL_W){1'b0}}, head_rec.label})
          report_mismatch($sformatf("label_out %0d, want %0d", out_tdata, head_rec.label));
        if (out_tlast !== head_rec.is_end)
          report_mismatch($sformatf("chain_end_out %0b, want %0b", out_tlast,
                                    head_rec.is_end));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("tb_short_label_run_merge failed");
        $finish;
      end
    end
  end

  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pass_through();
    test_merge_rules();
    test_config_mid_chain();
    test_saturation();
    test_backpressure();
    test_random_chains();
    drain_results(40);
    if (pending_labels.size() != 0)
      report_mismatch($sformatf("%0d labels never came out", pending_labels.size()));
    $display("Sent %0d labels in %0d chains, checked %0d output labels.",
             labels_sent, chains_sent, results_checked);
    $display("Min run length written %0d times, from 0 up past the ceiling.", cfg_writes);
    if (mismatches == 0) begin
      $display("tb_short_label_run_merge passed");
    end else begin
      $display("tb_short_label_run_merge failed");
    end
    $finish;
  end

endmodule
